// ===== rtl/sorted_priority_queue_unit_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the sorted priority queue
// Concurrent checks clocked on i_clk; empty under synthesis.
// ---------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// check that is off while reset is asserted
`define SPQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// check that holds on every edge, reset included
`define SPQ_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);
`else
`define SPQ_ASSERT(lbl, prop, msg)
`define SPQ_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== rtl/srtpq_pkg.sv =====
// ---------------------------------------------------------------------------
// Sorted priority queue package
// Sizes, command and status codes, and the stored entry type.
// ---------------------------------------------------------------------------
package srtpq_pkg;

    localparam int DEPTH      = 16;
    localparam int TAG_WIDTH  = 16;
    localparam int RANK_WIDTH = 32;
    localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int KIND_W     = 2;
    localparam int STATUS_W   = 2;

    localparam logic [KIND_W-1:0] KIND_ENQ   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DEQ   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic [RANK_WIDTH-1:0] rank;
        logic [TAG_WIDTH-1:0]  tag;
    } t_entry;

    // signed compare of two ranks: a is served after b
    function automatic logic rank_after(input logic [RANK_WIDTH-1:0] a,
                                        input logic [RANK_WIDTH-1:0] b);
        return $signed(a) > $signed(b);
    endfunction

endpackage

// ===== rtl/sorted_priority_queue_unit.sv =====
// ---------------------------------------------------------------------------
// Sorted priority queue unit
// Keeps up to DEPTH (tag, rank) entries in one memory, sorted by ascending
// signed rank; enqueue inserts behind equal ranks, dequeue pops the head.
// ---------------------------------------------------------------------------
// Timing: clear, undefined kinds, drops, empty dequeues and one-entry cases finish
//   in the accept cycle; enqueue walks down past larger ranks, then writes the entry;
//   dequeue walks up, shifting entries down. The result word shows in the next cycle.
// Throughput: one command at a time; one entry moves per cycle (one read, one write).
// Reset: synchronous, clears the count and control; entries need no clear.
//   The result receiver cannot stall: o_valid lasts exactly one cycle.
module sorted_priority_queue_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [srtpq_pkg::KIND_W-1:0]        i_kind,
    input  logic [srtpq_pkg::TAG_WIDTH-1:0]     i_tag,
    input  logic signed [srtpq_pkg::RANK_WIDTH-1:0] i_rank,
    output logic                                o_valid,
    output logic [srtpq_pkg::STATUS_W-1:0]      o_status,
    output logic [srtpq_pkg::TAG_WIDTH-1:0]     o_removed_tag,
    output logic [srtpq_pkg::TAG_WIDTH-1:0]     o_head_tag,
    output logic signed [srtpq_pkg::RANK_WIDTH-1:0] o_head_rank,
    output logic [srtpq_pkg::CNT_W-1:0]         o_occupancy,
    output logic                                o_is_empty
);
    import srtpq_pkg::*;

    `include "sorted_priority_queue_unit_assert.svh"

    // sequencer states
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_INS   = 2'd1;  // walk down, shifting larger ranks up
    localparam logic [1:0] S_PUT   = 2'd2;  // place new entry at the head slot
    localparam logic [1:0] S_SHIFT = 2'd3;  // walk up, shifting entries down

    // entry memory: one write and one registered read per cycle
    t_entry mem [DEPTH];
    t_entry r_rdata;

    logic [1:0]           r_state, n_state;
    logic [ADDR_W-1:0]    r_idx,   n_idx;
    logic [CNT_W-1:0]     r_held,  n_held;
    t_entry               r_head,  n_head;
    t_entry               r_new,   n_new;
    logic [TAG_WIDTH-1:0] r_removed, n_removed;

    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_waddr;
    t_entry               mem_wdata;
    logic [ADDR_W-1:0]    mem_raddr;

    logic                 fin;
    logic [STATUS_W-1:0]  fin_status;
    logic                 accept;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[mem_raddr];
    end

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_held     = r_held;
        n_head     = r_head;
        n_new      = r_new;
        n_removed  = r_removed;
        mem_we     = 1'b0;
        mem_waddr  = r_idx;
        mem_wdata  = r_new;
        mem_raddr  = r_idx;
        fin        = 1'b0;
        fin_status = STAT_DONE;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_new     = '{rank: i_rank, tag: i_tag};
                    n_removed = '0;
                    case (i_kind)
                        KIND_ENQ: begin
                            if (r_held >= CNT_W'(DEPTH)) begin
                                // drop: queue full
                                fin        = 1'b1;
                                fin_status = STAT_FULL;
                            end else if (r_held == '0) begin
                                mem_we    = 1'b1;
                                mem_waddr = '0;
                                mem_wdata = n_new;
                                n_head    = n_new;
                                n_held    = CNT_W'(1);
                                fin       = 1'b1;
                            end else begin
                                // start at the tail, read the last entry
                                n_idx     = r_held[ADDR_W-1:0];
                                mem_raddr = r_held[ADDR_W-1:0] - 1'b1;
                                n_state   = S_INS;
                            end
                        end
                        KIND_DEQ: begin
                            if (r_held == '0) begin
                                fin        = 1'b1;
                                fin_status = STAT_EMPTY;
                            end else if (r_held == CNT_W'(1)) begin
                                n_removed = r_head.tag;
                                n_held    = '0;
                                fin       = 1'b1;
                            end else begin
                                n_removed = r_head.tag;
                                n_idx     = ADDR_W'(1);
                                mem_raddr = ADDR_W'(1);
                                n_state   = S_SHIFT;
                            end
                        end
                        KIND_CLEAR: begin
                            n_held = '0;
                            fin    = 1'b1;
                        end
                        default: begin
                            // no-op command: report current head
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            S_INS: begin
                if (rank_after(r_rdata.rank, r_new.rank)) begin
                    // move the larger entry up one slot
                    mem_we    = 1'b1;
                    mem_waddr = r_idx;
                    mem_wdata = r_rdata;
                    n_idx     = r_idx - 1'b1;
                    if (r_idx == ADDR_W'(1)) begin
                        n_state = S_PUT;
                    end else begin
                        mem_raddr = r_idx - ADDR_W'(2);
                    end
                end else begin
                    // slot found behind an equal or smaller rank
                    mem_we    = 1'b1;
                    mem_waddr = r_idx;
                    mem_wdata = r_new;
                    n_held    = r_held + 1'b1;
                    n_state   = S_IDLE;
                    fin       = 1'b1;
                end
            end
            S_PUT: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx;
                mem_wdata = r_new;
                n_head    = r_new;
                n_held    = r_held + 1'b1;
                n_state   = S_IDLE;
                fin       = 1'b1;
            end
            S_SHIFT: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx - 1'b1;
                mem_wdata = r_rdata;
                if (r_idx == ADDR_W'(1)) begin
                    n_head = r_rdata;
                end
                if ((CNT_W'(r_idx) + CNT_W'(1)) < r_held) begin
                    mem_raddr = r_idx + 1'b1;
                    n_idx     = r_idx + 1'b1;
                end else begin
                    n_held  = r_held - 1'b1;
                    n_state = S_IDLE;
                    fin     = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_held  <= '0;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_held  <= n_held;
            o_valid <= fin;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_head    <= n_head;
        r_new     <= n_new;
        r_removed <= n_removed;
        if (fin) begin
            o_status      <= fin_status;
            o_removed_tag <= n_removed;
            o_head_tag    <= (n_held != '0) ? n_head.tag : '0;
            o_head_rank   <= (n_held != '0) ? $signed(n_head.rank) : '0;
            o_occupancy   <= n_held;
            o_is_empty    <= (n_held == '0);
        end
    end

    // count stays within the memory
    `SPQ_ASSERT(a_held_bound, r_held <= CNT_W'(DEPTH), "entry count above depth")
    // a result word never shows while a command is still in flight
    `SPQ_ASSERT(a_valid_idle, o_valid |-> !busy, "result shown while busy")
    // count only moves at the end of a command
    `SPQ_ASSERT(a_held_hold, (busy && !fin) |=> $stable(r_held), "count moved mid command")
    // shift-down walk never addresses below the head slot
    `SPQ_ASSERT(a_shift_idx, (r_state == S_SHIFT) |-> (r_idx != '0), "shift index at zero")
    // empty flag agrees with the count it reports
    `SPQ_ASSERT(a_empty_flag, o_valid |-> (o_is_empty == (o_occupancy == '0)),
        "empty flag mismatch")

endmodule

// ===== test/testbench.sv =====
// ---------------------------------------------------------------------------
// Sorted priority queue unit testbench
// Drives enqueue, dequeue, clear and undefined commands through the
// start/busy handshake. A scoreboard keeps its own sorted copy of the queue,
// predicts the result word of every accepted command and checks each strobed
// result against the oldest prediction, field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import srtpq_pkg::*;

    // Kind 3 carries no command; the block must leave the queue alone.
    localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

    // Longest command is an enqueue that walks past every entry; allow plenty
    // beyond that before the final verdict.
    localparam int SETTLE_CYCLES = 4 * (DEPTH + 2);
    localparam int RANDOM_WORDS  = 1000;

    // One result word as the block reports it after a command.
    typedef struct {
        logic [STATUS_W-1:0]   status;
        logic [TAG_WIDTH-1:0]  removed_tag;
        logic [TAG_WIDTH-1:0]  head_tag;
        logic [RANK_WIDTH-1:0] head_rank;
        logic [CNT_W-1:0]      occupancy;
        logic                  is_empty;
    } t_queue_report;

    // Scoreboard: a shadow of the sorted queue plus the reports still due.
    class t_queue_tracker;
        logic [RANK_WIDTH-1:0] ranks [DEPTH];
        logic [TAG_WIDTH-1:0]  tags  [DEPTH];
        int                    held;
        t_queue_report         due [$];
        int                    failures;

        function new();
            held     = 0;
            failures = 0;
        endfunction

        function int outstanding();
            return due.size();
        endfunction

        // Apply one accepted command to the shadow and queue its report.
        function void note_command(input logic [KIND_W-1:0] kind,
                                   input logic [TAG_WIDTH-1:0] tag,
                                   input logic [RANK_WIDTH-1:0] rank);
            t_queue_report r;
            int            pos;
            r.status      = STAT_DONE;
            r.removed_tag = '0;
            case (kind)
                KIND_ENQ: begin
                    if (held >= DEPTH) begin
                        r.status = STAT_FULL;
                    end else begin
                        // shift later ranks back; equal ranks stay ahead
                        pos = held;
                        while (pos > 0 && $signed(ranks[pos-1]) > $signed(rank)) begin
                            ranks[pos] = ranks[pos-1];
                            tags[pos]  = tags[pos-1];
                            pos--;
                        end
                        ranks[pos] = rank;
                        tags[pos]  = tag;
                        held++;
                    end
                end
                KIND_DEQ: begin
                    if (held == 0) begin
                        r.status = STAT_EMPTY;
                    end else begin
                        r.removed_tag = tags[0];
                        for (pos = 0; pos + 1 < held; pos++) begin
                            ranks[pos] = ranks[pos+1];
                            tags[pos]  = tags[pos+1];
                        end
                        held--;
                    end
                end
                KIND_CLEAR: begin
                    held = 0;
                end
                default: begin
                end
            endcase
            r.head_tag  = (held != 0) ? tags[0]  : '0;
            r.head_rank = (held != 0) ? ranks[0] : '0;
            r.occupancy = held[CNT_W-1:0];
            r.is_empty  = (held == 0);
            due.push_back(r);
        endfunction

        task report_mismatch(input string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            failures++;
        endtask

        task check_field(input string name, input logic [63:0] got,
                         input logic [63:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
        endtask

        task check_result(input t_queue_report got);
            t_queue_report want;
            if (due.size() == 0) begin
                report_mismatch("result word with no command pending");
                return;
            end
            want = due.pop_front();
            check_field("status",      64'(got.status),      64'(want.status));
            check_field("removed_tag", 64'(got.removed_tag), 64'(want.removed_tag));
            check_field("head_tag",    64'(got.head_tag),    64'(want.head_tag));
            check_field("head_rank",   64'(got.head_rank),   64'(want.head_rank));
            check_field("occupancy",   64'(got.occupancy),   64'(want.occupancy));
            check_field("is_empty",    64'(got.is_empty),    64'(want.is_empty));
        endtask
    endclass

    // Every block input starts at a known value.
    logic                         i_clk   = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         start   = 1'b0;
    logic [KIND_W-1:0]            i_kind  = KIND_ENQ;
    logic [TAG_WIDTH-1:0]         i_tag   = '0;
    logic signed [RANK_WIDTH-1:0] i_rank  = '0;

    logic                         busy;
    logic                         o_valid;
    logic [STATUS_W-1:0]          o_status;
    logic [TAG_WIDTH-1:0]         o_removed_tag;
    logic [TAG_WIDTH-1:0]         o_head_tag;
    logic signed [RANK_WIDTH-1:0] o_head_rank;
    logic [CNT_W-1:0]             o_occupancy;
    logic                         o_is_empty;

    t_queue_tracker tracker = new();
    bit             idle_on = 1'b1;

    sorted_priority_queue_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_kind        (i_kind),
        .i_tag         (i_tag),
        .i_rank        (i_rank),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_removed_tag (o_removed_tag),
        .o_head_tag    (o_head_tag),
        .o_head_rank   (o_head_rank),
        .o_occupancy   (o_occupancy),
        .o_is_empty    (o_is_empty)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Send one command word. Optionally idle first, then hold start high
    // until an edge sees busy low; that edge accepts the word. Start is left
    // high so a back-to-back word needs no second assignment in the step.
    task send_command(input logic [KIND_W-1:0] kind,
                      input logic [TAG_WIDTH-1:0] tag,
                      input logic [RANK_WIDTH-1:0] rank);
        if (idle_on) begin
            while ($urandom_range(99) < 19) begin
                start <= 1'b0;
                @(posedge i_clk);
            end
        end
        start  <= 1'b1;
        i_kind <= kind;
        i_tag  <= tag;
        i_rank <= rank;
        do @(posedge i_clk); while (busy !== 1'b0);
        tracker.note_command(kind, tag, rank);
    endtask

    // Hold start low until every predicted result word has come back.
    task drain_results();
        start <= 1'b0;
        while (tracker.outstanding() != 0) @(posedge i_clk);
    endtask

    // Ranks: a few Q16.16 integers so ties and FIFO order show up, plus full
    // random values, the signed extremes and small raw values near zero.
    function automatic logic [RANK_WIDTH-1:0] pick_rank();
        int sel;
        sel = $urandom_range(99);
        if (sel < 40)
            return RANK_WIDTH'(($urandom_range(4) - 2) <<< 16);
        else if (sel < 70)
            return $urandom();
        else if (sel < 85) begin
            case ($urandom_range(3))
                0: return {1'b1, {(RANK_WIDTH-1){1'b0}}};
                1: return {1'b0, {(RANK_WIDTH-1){1'b1}}};
                2: return '0;
                default: return '1;
            endcase
        end
        return RANK_WIDTH'($urandom_range(15) - 8);
    endfunction

    // Sample result words at the edge that ends their strobe cycle.
    always @(posedge i_clk) begin
        t_queue_report got;
        if (i_rst_n && o_valid === 1'b1) begin
            got.status      = o_status;
            got.removed_tag = o_removed_tag;
            got.head_tag    = o_head_tag;
            got.head_rank   = o_head_rank;
            got.occupancy   = o_occupancy;
            got.is_empty    = o_is_empty;
            tracker.check_result(got);
        end
    end

    initial begin
        int phase;
        int pick;
        logic [KIND_W-1:0] kind;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty-queue cases first.
        send_command(KIND_DEQ, 16'h0000, '0);          // dequeue on empty
        send_command(KIND_NONE, 16'hffff, '1);         // undefined kind, empty
        // Extreme ranks and tags; a new lowest rank takes the head.
        send_command(KIND_ENQ, 16'hffff, 32'h7fff_ffff);
        send_command(KIND_ENQ, 16'h0000, 32'h8000_0000);
        send_command(KIND_ENQ, 16'h1234, 32'h0000_0000);
        send_command(KIND_ENQ, 16'h5555, 32'h0000_0000); // tie: goes behind
        send_command(KIND_ENQ, 16'haaaa, 32'hffff_ffff); // -1 sorts before 0
        // Fill to capacity with ties spread through the queue.
        for (int n = 0; n < DEPTH - 5; n++)
            send_command(KIND_ENQ, TAG_WIDTH'(16'h0100 + n), RANK_WIDTH'((n % 3 - 1) <<< 16));
        send_command(KIND_ENQ, 16'hbeef, 32'h8000_0000); // full: dropped
        send_command(KIND_NONE, 16'h0000, '0);           // undefined kind, full
        send_command(KIND_DEQ, 16'h0000, '0);
        send_command(KIND_DEQ, 16'h0000, '0);
        send_command(KIND_CLEAR, 16'h0000, '0);          // clear with entries
        send_command(KIND_CLEAR, 16'hffff, '1);          // clear on empty

        // Random: phases that fill, drain or mix so the queue swings between
        // empty and full, with clears and undefined kinds as noise.
        phase = 0;
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n % 60 == 0)
                phase = $urandom_range(2);
            // run a long stretch back to back
            idle_on = !(n >= 300 && n < 500);
            if (n == 150 || n == 600 || n == 900)
                drain_results();
            pick = $urandom_range(99);
            case (phase)
                0:       kind = (pick < 75) ? KIND_ENQ : (pick < 93) ? KIND_DEQ :
                                (pick < 97) ? KIND_CLEAR : KIND_NONE;
                1:       kind = (pick < 25) ? KIND_ENQ : (pick < 93) ? KIND_DEQ :
                                (pick < 97) ? KIND_CLEAR : KIND_NONE;
                default: kind = (pick < 50) ? KIND_ENQ : (pick < 92) ? KIND_DEQ :
                                (pick < 97) ? KIND_CLEAR : KIND_NONE;
            endcase
            send_command(kind, TAG_WIDTH'($urandom_range(16'hffff)), pick_rank());
        end

        // Wait out the remaining result words, then let the block settle.
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (tracker.failures == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    // Hang guard: far beyond the slowest legal run.
    initial begin
        #3_000_000;
        $display("testbench failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/srtpq_pkg.sv
rtl/sorted_priority_queue_unit.sv
test/testbench.sv
